### hw/rtl/afr_pkg.sv
`default_nettype none
package afr_pkg;

	localparam int HEADER_BYTES = 18;

	// Item operation codes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_LEVEL = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_UNIVERSE      = 2'd0;
	localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
	localparam logic [1:0] CFG_SEND_INTERVAL = 2'd2;

	// Fixed header content.
	localparam logic [7:0] ARTNET_ID [0:7] = '{8'h41, 8'h72, 8'h74, 8'h2D,
		8'h4E, 8'h65, 8'h74, 8'h00};
	localparam logic [15:0] OPCODE_DMX = 16'h5000;
	localparam logic [15:0] PROT_VER   = 16'h000E;

	// Byte positions inside one job: the header, then the data byte, then the pad.
	localparam logic [4:0] IDX_ID_FIRST = 5'd0;
	localparam logic [4:0] IDX_ID_LAST  = 5'd7;
	localparam logic [4:0] IDX_OP_LO    = 5'd8;
	localparam logic [4:0] IDX_OP_HI    = 5'd9;
	localparam logic [4:0] IDX_VER_HI   = 5'd10;
	localparam logic [4:0] IDX_VER_LO   = 5'd11;
	localparam logic [4:0] IDX_SEQ      = 5'd12;
	localparam logic [4:0] IDX_PHYS     = 5'd13;
	localparam logic [4:0] IDX_UNI_LO   = 5'd14;
	localparam logic [4:0] IDX_UNI_HI   = 5'd15;
	localparam logic [4:0] IDX_LEN_HI   = 5'd16;
	localparam logic [4:0] IDX_LEN_LO   = 5'd17;
	localparam logic [4:0] IDX_DATA     = 5'(HEADER_BYTES);
	localparam logic [4:0] IDX_PAD      = 5'(HEADER_BYTES + 1);

	typedef struct packed {
		logic        header;
		logic [7:0]  seq;
		logic [14:0] universe;
		logic [9:0]  len;
		logic [7:0]  data;
		logic        data_last;
		logic        pad;
	} afr_job_t;

endpackage
`default_nettype wire

### hw/rtl/artdmx_packet_framer.sv
`default_nettype none
// ArtDmx packet framer. Items arrive as millisecond ticks or channel levels
// (signed Q8.8) and each level of a frame that is sent becomes one DMX byte;
// levels of a frame that is not sent are dropped. A sent frame's first level
// produces the 18-byte ArtDmx header followed by that channel's byte, and the
// last level of a frame of odd length adds a pad byte; while the byte emitter
// works through a job, in_stall is high. Other sent levels give one byte each,
// and ticks give none. The output beat is registered, so a new item is taken
// while a result still waits. Configuration takes effect at the next frame;
// cfg_ready is always high.
module artdmx_packet_framer #(
	parameter int MAX_CHANNELS = 512
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [1:0]        cfg_index,
	input  wire  [15:0]       cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               operation,
	input  wire signed [15:0] level,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [7:0]        packet_byte,
	output logic              last_byte
);
	import afr_pkg::*;

	logic     take;
	logic     push;
	logic     busy;
	afr_job_t job;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign take      = in_valid && !busy;

	afr_frame_ctrl #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.operation(operation),
		.level    (level),
		.push     (push),
		.job      (job)
	);

	afr_byte_emitter u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.job        (job),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.packet_byte(packet_byte),
		.last_byte  (last_byte)
	);

endmodule
`default_nettype wire

### hw/rtl/afr_frame_ctrl.sv
`default_nettype none
module afr_frame_ctrl #(
	parameter int MAX_CHANNELS = 512
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_valid,
	input  wire  [1:0]       cfg_index,
	input  wire  [15:0]      cfg_data,
	input  wire              take,
	input  wire              operation,
	input  wire signed [15:0] level,
	output logic             push,
	output afr_pkg::afr_job_t job
);
	import afr_pkg::*;

	logic [14:0] universe_q;
	logic [9:0]  channel_count_q;
	logic [15:0] send_interval_q;
	logic [15:0] ticks_q;
	logic        first_q;
	logic [7:0]  seq_q;
	logic [9:0]  chan_idx_q;
	logic        sending_q;
	logic [9:0]  frame_len_q;

	logic [9:0]  eff_count;
	logic        start;
	logic [9:0]  flen;
	logic        sending;
	logic        last;
	logic        pad;
	logic [7:0]  seq_inc;
	logic [7:0]  seq_next;
	logic [23:0] prod;
	logic [7:0]  dmx_byte;

	always_comb begin
		eff_count = channel_count_q;
		if (channel_count_q == 10'd0)
			eff_count = 10'd1;
		else if (channel_count_q > 10'(MAX_CHANNELS))
			eff_count = 10'(MAX_CHANNELS);
	end

	// Level times 255, rounded: negative levels give zero, large ones saturate.
	always_comb begin
		prod = 24'(level[14:0]) * 24'd255 + 24'd128;
		if (level[15])
			dmx_byte = 8'd0;
		else if (prod[23:16] != 8'd0)
			dmx_byte = 8'hFF;
		else
			dmx_byte = prod[15:8];
	end

	always_comb begin
		start    = (chan_idx_q == 10'd0);
		flen     = start ? eff_count : frame_len_q;
		sending  = start ? (first_q || ticks_q >= send_interval_q) : sending_q;
		last     = ({1'b0, chan_idx_q} + 11'd1) >= {1'b0, flen};
		pad      = last && flen[0];
		seq_inc  = seq_q + 8'd1;
		seq_next = (seq_inc == 8'd0) ? 8'd1 : seq_inc;
	end

	assign push = take && (operation == OP_LEVEL) && sending;

	always_comb begin
		job.header    = start;
		job.seq       = seq_next;
		job.universe  = universe_q;
		job.len       = flen + {9'd0, flen[0]};
		job.data      = dmx_byte;
		job.data_last = last && !pad;
		job.pad       = pad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_q      <= 15'd0;
			channel_count_q <= 10'd3;
			send_interval_q <= 16'd23;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_UNIVERSE:      universe_q      <= cfg_data[14:0];
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[9:0];
				CFG_SEND_INTERVAL: send_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q     <= 16'd0;
			first_q     <= 1'b1;
			seq_q       <= 8'd0;
			chan_idx_q  <= 10'd0;
			sending_q   <= 1'b0;
			frame_len_q <= 10'd0;
		end else if (take) begin
			if (operation == OP_TICK) begin
				if (ticks_q != 16'hFFFF)
					ticks_q <= ticks_q + 16'd1;
			end else begin
				if (start) begin
					frame_len_q <= eff_count;
					if (sending) begin
						seq_q   <= seq_next;
						ticks_q <= 16'd0;
						first_q <= 1'b0;
					end
				end
				if (last) begin
					chan_idx_q <= 10'd0;
					sending_q  <= 1'b0;
				end else begin
					chan_idx_q <= chan_idx_q + 10'd1;
					sending_q  <= sending;
				end
			end
		end
	end

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		chan_idx_q != 10'd0 |-> chan_idx_q < frame_len_q)
		else $error("channel index beyond latched frame length");

	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> seq_q != 8'd0)
		else $error("sequence number zero after a packet was sent");

endmodule
`default_nettype wire

### hw/rtl/afr_byte_emitter.sv
`default_nettype none
module afr_byte_emitter (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  afr_pkg::afr_job_t job,
	output logic             busy,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [7:0]       packet_byte,
	output logic             last_byte
);
	import afr_pkg::*;

	afr_job_t   job_q;
	logic       job_valid_q;
	logic [4:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       out_load;
	logic [4:0] final_idx;
	logic       job_done;
	logic [7:0] sel_byte;
	logic       sel_last;

	assign out_load  = job_valid_q && (!out_valid_q || !out_stall);
	assign final_idx = job_q.pad ? IDX_PAD : IDX_DATA;
	assign job_done  = out_load && (idx_q == final_idx);
	// The next job may enter in the cycle that the current one hands over its final beat.
	assign busy      = job_valid_q && !job_done;

	always_comb begin
		sel_byte = 8'd0;
		case (idx_q) inside
			[IDX_ID_FIRST:IDX_ID_LAST]: sel_byte = ARTNET_ID[idx_q[2:0]];
			IDX_OP_LO:  sel_byte = OPCODE_DMX[7:0];
			IDX_OP_HI:  sel_byte = OPCODE_DMX[15:8];
			IDX_VER_HI: sel_byte = PROT_VER[15:8];
			IDX_VER_LO: sel_byte = PROT_VER[7:0];
			IDX_SEQ:    sel_byte = job_q.seq;
			IDX_PHYS:   sel_byte = 8'd0;
			IDX_UNI_LO: sel_byte = job_q.universe[7:0];
			IDX_UNI_HI: sel_byte = {1'b0, job_q.universe[14:8]};
			IDX_LEN_HI: sel_byte = {6'd0, job_q.len[9:8]};
			IDX_LEN_LO: sel_byte = job_q.len[7:0];
			IDX_DATA:   sel_byte = job_q.data;
			default:    sel_byte = 8'd0;
		endcase
		sel_last = (idx_q == IDX_DATA) ? job_q.data_last : (idx_q == IDX_PAD);
	end

	always_ff @(posedge clk) begin
		if (push)
			job_q <= job;
		if (out_load) begin
			byte_q <= sel_byte;
			last_q <= sel_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				job_valid_q <= 1'b1;
				idx_q       <= job.header ? IDX_ID_FIRST : IDX_DATA;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end else if (out_load) begin
				idx_q <= idx_q + 5'd1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_byte = byte_q;
	assign last_byte   = last_q;

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !busy)
		else $error("job pushed while the emitter is still busy");

	a_header_starts: assert property (@(posedge clk) disable iff (!arst_n)
		push && job.header |=> job_valid_q && idx_q == IDX_ID_FIRST)
		else $error("header job did not start at the first header byte");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> idx_q <= final_idx)
		else $error("byte position ran past the end of the job");

endmodule
`default_nettype wire
